// ===== rtl/vtgd_pkg.sv =====
// shared types, codes and helpers for the vector tile geometry decoder
`default_nettype none

package vtgd_pkg;

    localparam int CODE_BITS  = 3;
    localparam int WORD_BITS  = 32;
    localparam int COUNT_BITS = WORD_BITS - CODE_BITS;

    localparam logic [CODE_BITS-1:0] CMD_MOVE  = 3'd1;
    localparam logic [CODE_BITS-1:0] CMD_LINE  = 3'd2;
    localparam logic [CODE_BITS-1:0] CMD_CLOSE = 3'd7;

    typedef enum logic [2:0] {
        EV_HEADER  = 3'd0,
        EV_XHELD   = 3'd1,
        EV_MOVE    = 3'd2,
        EV_LINE    = 3'd3,
        EV_CLOSE   = 3'd4,
        EV_EMPTY   = 3'd5,
        EV_UNKNOWN = 3'd6,
        EV_IGNORED = 3'd7
    } event_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  pos_x;
        logic [WORD_BITS-1:0]  pos_y;
        logic [CODE_BITS-1:0]  active_cmd;
        logic [COUNT_BITS-1:0] repeats_left;
        logic                  await_y;
        logic [WORD_BITS-1:0]  held_dx;
        logic [WORD_BITS-1:0]  verts_since_close;
        logic                  ring_open;
        logic                  error_seen;
        logic [WORD_BITS-1:0]  cnt_cmd;
        logic [WORD_BITS-1:0]  cnt_move;
        logic [WORD_BITS-1:0]  cnt_line;
        logic [WORD_BITS-1:0]  cnt_close;
        logic [WORD_BITS-1:0]  cnt_degen;
        logic [WORD_BITS-1:0]  cnt_empty;
    } state_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 feature_start;
        logic                 layer_start;
    } request_t;

    typedef struct packed {
        event_t                ev;
        logic [WORD_BITS-1:0]  cursor_x;
        logic [WORD_BITS-1:0]  cursor_y;
        logic                  ring_break;
        logic [COUNT_BITS-1:0] closes;
        logic [WORD_BITS-1:0]  command_total;
        logic [WORD_BITS-1:0]  move_total;
        logic [WORD_BITS-1:0]  line_total;
        logic [WORD_BITS-1:0]  close_total;
        logic [WORD_BITS-1:0]  degenerate_total;
        logic [WORD_BITS-1:0]  empty_total;
    } result_t;

    function automatic logic [WORD_BITS-1:0] unzigzag(input logic [WORD_BITS-1:0] z);
        return (z >> 1) ^ {WORD_BITS{z[0]}};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vtgd_step.sv =====
// next-state and result logic for one geometry word
`default_nettype none

module vtgd_step (
    input  vtgd_pkg::state_t   cur,
    input  vtgd_pkg::request_t req,
    output vtgd_pkg::state_t   nxt,
    output vtgd_pkg::result_t  res
);

    always_comb
    begin
        vtgd_pkg::state_t                    s;
        logic [vtgd_pkg::CODE_BITS-1:0]      cmd;
        logic [vtgd_pkg::COUNT_BITS-1:0]     count;
        logic [vtgd_pkg::COUNT_BITS-1:0]     degen;
        vtgd_pkg::event_t                    ev;
        logic                                brk;
        logic [vtgd_pkg::COUNT_BITS-1:0]     closes;

        s      = cur;
        cmd    = req.word[vtgd_pkg::CODE_BITS-1:0];
        count  = req.word[vtgd_pkg::WORD_BITS-1:vtgd_pkg::CODE_BITS];
        degen  = '0;
        brk    = 1'b0;
        closes = '0;
        ev     = vtgd_pkg::EV_IGNORED;

        // layer start clears counters and also starts a feature
        if (req.layer_start)
        begin
            s.cnt_cmd   = '0;
            s.cnt_move  = '0;
            s.cnt_line  = '0;
            s.cnt_close = '0;
            s.cnt_degen = '0;
            s.cnt_empty = '0;
        end
        if (req.feature_start || req.layer_start)
        begin
            s.pos_x             = '0;
            s.pos_y             = '0;
            s.active_cmd        = '0;
            s.repeats_left      = '0;
            s.await_y           = 1'b0;
            s.held_dx           = '0;
            s.verts_since_close = '0;
            s.ring_open         = 1'b0;
            s.error_seen        = 1'b0;
        end

        if (s.error_seen)
        begin
            ev = vtgd_pkg::EV_IGNORED;
        end
        else if (s.repeats_left == '0)
        begin
            s.cnt_cmd    = s.cnt_cmd + 1'b1;
            s.active_cmd = cmd;
            s.await_y    = 1'b0;
            if (count == '0)
            begin
                s.cnt_empty = s.cnt_empty + 1'b1;
                ev          = vtgd_pkg::EV_EMPTY;
            end
            else if (cmd == vtgd_pkg::CMD_MOVE || cmd == vtgd_pkg::CMD_LINE)
            begin
                s.repeats_left = count;
                ev             = vtgd_pkg::EV_HEADER;
            end
            else if (cmd == vtgd_pkg::CMD_CLOSE)
            begin
                degen               = (s.verts_since_close <= 32'd2) ? count : count - 1'b1;
                s.cnt_close         = s.cnt_close + {{vtgd_pkg::CODE_BITS{1'b0}}, count};
                s.cnt_degen         = s.cnt_degen + {{vtgd_pkg::CODE_BITS{1'b0}}, degen};
                s.verts_since_close = '0;
                s.ring_open         = 1'b0;
                closes              = count;
                ev                  = vtgd_pkg::EV_CLOSE;
            end
            else
            begin
                s.error_seen = 1'b1;
                ev           = vtgd_pkg::EV_UNKNOWN;
            end
        end
        else if (!s.await_y)
        begin
            s.held_dx = vtgd_pkg::unzigzag(req.word);
            s.await_y = 1'b1;
            ev        = vtgd_pkg::EV_XHELD;
        end
        else
        begin
            s.pos_x        = s.pos_x + s.held_dx;
            s.pos_y        = s.pos_y + vtgd_pkg::unzigzag(req.word);
            s.await_y      = 1'b0;
            s.repeats_left = s.repeats_left - 1'b1;
            if (s.verts_since_close != '1)
            begin
                s.verts_since_close = s.verts_since_close + 1'b1;
            end
            if (s.active_cmd == vtgd_pkg::CMD_MOVE)
            begin
                brk        = s.ring_open;
                s.cnt_move = s.cnt_move + 1'b1;
                ev         = vtgd_pkg::EV_MOVE;
            end
            else
            begin
                s.cnt_line = s.cnt_line + 1'b1;
                ev         = vtgd_pkg::EV_LINE;
            end
            s.ring_open = 1'b1;
        end

        nxt                  = s;
        res.ev               = ev;
        res.cursor_x         = s.pos_x;
        res.cursor_y         = s.pos_y;
        res.ring_break       = brk;
        res.closes           = closes;
        res.command_total    = s.cnt_cmd;
        res.move_total       = s.cnt_move;
        res.line_total       = s.cnt_line;
        res.close_total      = s.cnt_close;
        res.degenerate_total = s.cnt_degen;
        res.empty_total      = s.cnt_empty;
    end

endmodule

`default_nettype wire

// ===== rtl/vector_tile_geometry_decoder_core.sv =====
// top level of the vector tile geometry decoder
//
// channel | handshake            | payload
// --------+----------------------+------------------------------------------------
// input   | in_valid / in_ready  | geometry_word, feature_start, layer_start
// output  | out_valid / out_ready| event_res, cursor_x/y, ring_break, closes_in_item,
//         |                      | command/move/line/close/degenerate/empty totals
//
// one request per cycle sustained while out_ready is high; each result passes through
// the input register, then decode logic into the result register
// rst_n clears decoder state, layer counters and both valid flags
// output stall holds the result register and backs up into the input register
`default_nettype none

module vector_tile_geometry_decoder_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [31:0]         geometry_word,
    input  wire logic                feature_start,
    input  wire logic                layer_start,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               event_res,
    output logic signed [31:0]       cursor_x,
    output logic signed [31:0]       cursor_y,
    output logic                     ring_break,
    output logic [28:0]              closes_in_item,
    output logic [31:0]              command_total,
    output logic [31:0]              move_total,
    output logic [31:0]              line_total,
    output logic [31:0]              close_total,
    output logic [31:0]              degenerate_total,
    output logic [31:0]              empty_total
);

    vtgd_pkg::request_t req_reg;
    logic               req_valid_reg;
    vtgd_pkg::state_t   state_reg;
    vtgd_pkg::state_t   state_next;
    vtgd_pkg::result_t  res_reg;
    vtgd_pkg::result_t  res_next;
    logic               res_valid_reg;
    logic               res_free;
    logic               advance;

    assign res_free = !res_valid_reg || out_ready;
    assign advance  = req_valid_reg && res_free;
    assign in_ready = !req_valid_reg || res_free;

    vtgd_step u_step (
        .cur (state_reg),
        .req (req_reg),
        .nxt (state_next),
        .res (res_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.word          <= geometry_word;
            req_reg.feature_start <= feature_start;
            req_reg.layer_start   <= layer_start;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = res_valid_reg;
    assign event_res        = res_reg.ev;
    assign cursor_x         = $signed(res_reg.cursor_x);
    assign cursor_y         = $signed(res_reg.cursor_y);
    assign ring_break       = res_reg.ring_break;
    assign closes_in_item   = res_reg.closes;
    assign command_total    = res_reg.command_total;
    assign move_total       = res_reg.move_total;
    assign line_total       = res_reg.line_total;
    assign close_total      = res_reg.close_total;
    assign degenerate_total = res_reg.degenerate_total;
    assign empty_total      = res_reg.empty_total;

endmodule

`default_nettype wire

// ===== tb/tb_vector_tile_geometry_decoder_core.sv =====
// self-checking testbench for the vector tile geometry decoder core
`timescale 1ns / 100ps

module tb_vector_tile_geometry_decoder_core;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        geometry_word;
    logic               feature_start;
    logic               layer_start;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         event_res;
    logic signed [31:0] cursor_x;
    logic signed [31:0] cursor_y;
    logic               ring_break;
    logic [28:0]        closes_in_item;
    logic [31:0]        command_total;
    logic [31:0]        move_total;
    logic [31:0]        line_total;
    logic [31:0]        close_total;
    logic [31:0]        degenerate_total;
    logic [31:0]        empty_total;

    vector_tile_geometry_decoder_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .geometry_word    (geometry_word),
        .feature_start    (feature_start),
        .layer_start      (layer_start),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_res        (event_res),
        .cursor_x         (cursor_x),
        .cursor_y         (cursor_y),
        .ring_break       (ring_break),
        .closes_in_item   (closes_in_item),
        .command_total    (command_total),
        .move_total       (move_total),
        .line_total       (line_total),
        .close_total      (close_total),
        .degenerate_total (degenerate_total),
        .empty_total      (empty_total)
    );

    // decoder state mirror
    logic [31:0] cur_x = '0;
    logic [31:0] cur_y = '0;
    logic [2:0]  pend_cmd = '0;
    logic [28:0] pairs_left = '0;
    logic        have_dx = 1'b0;
    logic [31:0] saved_dx = '0;
    logic [31:0] verts_since = '0;
    logic        ring_live = 1'b0;
    logic        halted = 1'b0;
    logic [31:0] n_cmd = '0;
    logic [31:0] n_move = '0;
    logic [31:0] n_line = '0;
    logic [31:0] n_close = '0;
    logic [31:0] n_degen = '0;
    logic [31:0] n_empty = '0;

    vtgd_pkg::result_t decoded_events[$];
    vtgd_pkg::result_t want;

    int mismatches = 0;
    int results_checked = 0;
    int words_sent = 0;
    int features_sent = 0;
    int layers_sent = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    bit force_ready = 1'b0;
    int hold_request = 0;
    logic lead_fs = 1'b0;
    logic lead_ls = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("vector_tile_geometry_decoder_core: mismatch");
        $finish;
    end

    function automatic logic [31:0] zigzag_delta(input logic [31:0] z);
        return {1'b0, z[31:1]} ^ {32{z[0]}};
    endfunction

    function automatic vtgd_pkg::result_t decode_word(input logic [31:0] w, input logic fs,
                                                      input logic ls);
        vtgd_pkg::result_t r;
        logic [2:0]        code;
        logic [28:0]       reps;
        r = '0;
        if (ls)
        begin
            n_cmd = '0;
            n_move = '0;
            n_line = '0;
            n_close = '0;
            n_degen = '0;
            n_empty = '0;
        end
        if (fs || ls)
        begin
            cur_x = '0;
            cur_y = '0;
            pend_cmd = '0;
            pairs_left = '0;
            have_dx = 1'b0;
            saved_dx = '0;
            verts_since = '0;
            ring_live = 1'b0;
            halted = 1'b0;
        end
        if (halted)
            r.ev = vtgd_pkg::EV_IGNORED;
        else if (pairs_left == 0)
        begin
            code = w[2:0];
            reps = w[31:3];
            n_cmd += 32'd1;
            pend_cmd = code;
            have_dx = 1'b0;
            if (reps == 0)
            begin
                n_empty += 32'd1;
                r.ev = vtgd_pkg::EV_EMPTY;
            end
            else if (code == vtgd_pkg::CMD_MOVE || code == vtgd_pkg::CMD_LINE)
            begin
                pairs_left = reps;
                r.ev = vtgd_pkg::EV_HEADER;
            end
            else if (code == vtgd_pkg::CMD_CLOSE)
            begin
                // only the first close action can see a real ring
                n_close += 32'(reps);
                n_degen += (verts_since <= 32'd2) ? 32'(reps) : 32'(reps) - 32'd1;
                verts_since = '0;
                ring_live = 1'b0;
                r.closes = reps;
                r.ev = vtgd_pkg::EV_CLOSE;
            end
            else
            begin
                halted = 1'b1;
                r.ev = vtgd_pkg::EV_UNKNOWN;
            end
        end
        else if (!have_dx)
        begin
            saved_dx = zigzag_delta(w);
            have_dx = 1'b1;
            r.ev = vtgd_pkg::EV_XHELD;
        end
        else
        begin
            cur_x += saved_dx;
            cur_y += zigzag_delta(w);
            have_dx = 1'b0;
            pairs_left -= 29'd1;
            if (verts_since != '1)
                verts_since += 32'd1;
            if (pend_cmd == vtgd_pkg::CMD_MOVE)
            begin
                r.ring_break = ring_live;
                n_move += 32'd1;
                r.ev = vtgd_pkg::EV_MOVE;
            end
            else
            begin
                n_line += 32'd1;
                r.ev = vtgd_pkg::EV_LINE;
            end
            ring_live = 1'b1;
        end
        r.cursor_x = cur_x;
        r.cursor_y = cur_y;
        r.command_total = n_cmd;
        r.move_total = n_move;
        r.line_total = n_line;
        r.close_total = n_close;
        r.degenerate_total = n_degen;
        r.empty_total = n_empty;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_v);
        if (mismatches < 40)
            $display("result %0d: %s got %h expected %h", results_checked, what, got, exp_v);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_events.size() == 0)
                report_mismatch("result with no request pending", {29'd0, event_res}, '0);
            else
            begin
                want = decoded_events.pop_front();
                if (event_res !== want.ev)
                    report_mismatch("event_res", {29'd0, event_res}, {29'd0, want.ev});
                if (cursor_x !== want.cursor_x)
                    report_mismatch("cursor_x", cursor_x, want.cursor_x);
                if (cursor_y !== want.cursor_y)
                    report_mismatch("cursor_y", cursor_y, want.cursor_y);
                if (ring_break !== want.ring_break)
                    report_mismatch("ring_break", {31'd0, ring_break}, {31'd0, want.ring_break});
                if (closes_in_item !== want.closes)
                    report_mismatch("closes_in_item", {3'd0, closes_in_item}, {3'd0, want.closes});
                if (command_total !== want.command_total)
                    report_mismatch("command_total", command_total, want.command_total);
                if (move_total !== want.move_total)
                    report_mismatch("move_total", move_total, want.move_total);
                if (line_total !== want.line_total)
                    report_mismatch("line_total", line_total, want.line_total);
                if (close_total !== want.close_total)
                    report_mismatch("close_total", close_total, want.close_total);
                if (degenerate_total !== want.degenerate_total)
                    report_mismatch("degenerate_total", degenerate_total, want.degenerate_total);
                if (empty_total !== want.empty_total)
                    report_mismatch("empty_total", empty_total, want.empty_total);
            end
            results_checked++;
        end
    end

    // output stall pattern, with long hold-offs on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else if (force_ready)
                out_ready = 1'b1;
            else
            begin
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    2: out_ready = (tick % 4) != 0;
                    default: out_ready = $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [31:0] w, input logic fs, input logic ls);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        geometry_word = w;
        feature_start = fs;
        layer_start = ls;
        in_valid = 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        decoded_events.insert(decoded_events.size(), decode_word(w, fs, ls));
        words_sent++;
        if (ls)
            layers_sent++;
        if (fs || ls)
            features_sent++;
        @(negedge clk);
    endtask

    task automatic send_next(input logic [31:0] w);
        send_word(w, lead_fs, lead_ls);
        lead_fs = 1'b0;
        lead_ls = 1'b0;
    endtask

    task automatic wait_results_drained();
        int n;
        in_valid = 1'b0;
        for (n = 0; n < 5000 && decoded_events.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] delta_word();
        if ($urandom_range(0, 9) < 7)
            return 32'($urandom_range(0, 64));
        return $urandom();
    endfunction

    task automatic send_feature(input bit new_layer);
        int         ncmd;
        int         kind;
        int         k;
        int         reps;
        logic [2:0] code;
        lead_fs = 1'b1;
        lead_ls = new_layer;
        if (new_layer && $urandom_range(0, 3) == 0)
            lead_fs = 1'b0;
        ncmd = $urandom_range(1, 6);
        for (k = 0; k < ncmd; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                reps = (kind < 35) ? $urandom_range(1, 2) : $urandom_range(1, 4);
                send_next({29'(reps), (kind < 35) ? vtgd_pkg::CMD_MOVE : vtgd_pkg::CMD_LINE});
                repeat (2 * reps) send_next(delta_word());
            end
            else if (kind < 85)
            begin
                reps = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 29'h1FFF_FFFF)
                                                   : $urandom_range(1, 2);
                send_next({29'(reps), vtgd_pkg::CMD_CLOSE});
            end
            else if (kind < 91)
                send_next({29'd0, 3'($urandom_range(0, 7))});
            else if (kind < 94)
            begin
                code = ($urandom_range(0, 4) == 0) ? 3'd0 : 3'($urandom_range(3, 6));
                send_next({29'($urandom_range(1, 29'h1FFF_FFFF)), code});
                repeat ($urandom_range(0, 3)) send_next($urandom());
                break;
            end
            else if (kind < 97)
            begin
                // truncated command, cut off by the next feature
                reps = $urandom_range(3, 29'h1FFF_FFFF);
                code = $urandom_range(0, 1) ? vtgd_pkg::CMD_MOVE : vtgd_pkg::CMD_LINE;
                send_next({29'(reps), code});
                repeat ($urandom_range(0, 4)) send_next(delta_word());
                break;
            end
            else
            begin
                send_next($urandom());
                break;
            end
        end
    endtask

    task automatic test_directed_cases();
        send_word(32'h0000_0009, 1'b0, 1'b1);
        send_word(32'hFFFF_FFFE, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0, 1'b0);
        send_word(32'h0000_0012, 1'b0, 1'b0);
        send_word(32'h0000_0002, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0001, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'h0000_0017, 1'b0, 1'b0);
        send_word(32'h0000_0011, 1'b0, 1'b0);
        send_word(32'h0000_0004, 1'b0, 1'b0);
        send_word(32'h0000_0004, 1'b0, 1'b0);
        send_word(32'h0000_0006, 1'b0, 1'b0);
        send_word(32'h0000_0007, 1'b0, 1'b0);
        send_word(32'h0000_000F, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'h0000_0007, 1'b0, 1'b0);
        send_word(32'h0000_001B, 1'b0, 1'b0);
        send_word(32'h0000_0012, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0009, 1'b1, 1'b0);
        send_word(32'h0000_0002, 1'b0, 1'b0);
        send_word(32'h0000_0011, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(32'h0000_0024, 1'b1, 1'b1);
        send_word(32'h0000_000D, 1'b1, 1'b0);
        send_word(32'h0000_0008, 1'b1, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_random_features();
        int goal;
        goal = words_sent + 1150;
        while (words_sent < goal)
            send_feature($urandom_range(0, 4) == 0);
        wait_results_drained();
    endtask

    task automatic test_output_hold_off();
        int goal;
        goal = words_sent + 150;
        gaps_on = 1'b0;
        hold_request = 300;
        while (words_sent < goal)
            send_feature($urandom_range(0, 5) == 0);
        gaps_on = 1'b1;
        wait_results_drained();
    endtask

    task automatic test_no_idle_stretch();
        int goal;
        goal = words_sent + 120;
        gaps_on = 1'b0;
        force_ready = 1'b1;
        while (words_sent < goal)
            send_feature($urandom_range(0, 4) == 0);
        wait_results_drained();
        gaps_on = 1'b1;
        force_ready = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        geometry_word = '0;
        feature_start = 1'b0;
        layer_start = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_random_features();
        test_output_hold_off();
        test_no_idle_stretch();
        if (decoded_events.size() != 0)
            report_mismatch("requests left without a result", decoded_events.size(), '0);
        $display("sent %0d geometry words in %0d features over %0d layers", words_sent,
                 features_sent, layers_sent);
        $display("checked %0d results, including a long output hold-off", results_checked);
        if (mismatches == 0)
            $display("vector_tile_geometry_decoder_core: match");
        else
            $display("vector_tile_geometry_decoder_core: mismatch");
        $finish;
    end

endmodule

// ===== vector_tile_geometry_decoder_core.f =====
rtl/vtgd_pkg.sv
rtl/vtgd_step.sv
rtl/vector_tile_geometry_decoder_core.sv
tb/tb_vector_tile_geometry_decoder_core.sv
